// ===== design/unfp_pkg.sv =====
// ----------------------------------------------------------------------------
// unfp_pkg
// shared types and constants for the ubx nav frame parser
// ----------------------------------------------------------------------------
package unfp_pkg;

   // sync pair that opens every frame
   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   // default upper bound on payload length
   localparam int unsigned MAX_PAYLOAD_DEFAULT = 128;

   // filter reset values: nav class, pvt id
   localparam logic [7:0] CLASS_FILTER_RESET = 8'h01;
   localparam logic [7:0] ID_FILTER_RESET    = 8'h07;

   // csr register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLASS_FILTER = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ID_FILTER    = 1'd1;

   typedef enum logic [1:0] {
      STATUS_NONE     = 2'd0,
      STATUS_GOOD     = 2'd1,
      STATUS_CK_FAIL  = 2'd2,
      STATUS_TOO_LONG = 2'd3
   } frame_status_type;

   // filter settings from the csr block to the parser
   typedef struct packed {
      logic [7:0] class_filter;
      logic [7:0] id_filter;
   } filter_type;

   // one response item
   typedef struct packed {
      logic [7:0]       frame_length;
      frame_status_type frame_status;
      logic [6:0]       payload_index;
      logic             payload_valid;
      logic [7:0]       payload_byte;
   } result_type;

endpackage

// ===== design/unfp_csr.sv =====
// ----------------------------------------------------------------------------
// unfp_csr
// class and id filter registers, written through the csr channel
// ----------------------------------------------------------------------------
module unfp_csr
   import unfp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                 csr_data,
   output filter_type                 filter
);

   filter_type filter_ff;
   filter_type filter_in;

   assign csr_ready = 1'b1;
   assign filter    = filter_ff;

   always_comb begin
      filter_in = filter_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CLASS_FILTER: filter_in.class_filter = csr_data;
            CSR_ID_FILTER:    filter_in.id_filter    = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff.class_filter <= CLASS_FILTER_RESET;
         filter_ff.id_filter    <= ID_FILTER_RESET;
      end else begin
         filter_ff <= filter_in;
      end
   end

endmodule

// ===== design/unfp_parser.sv =====
// ----------------------------------------------------------------------------
// unfp_parser
// frame state machine, fletcher-8 sums and the response register
// ----------------------------------------------------------------------------
module unfp_parser
   import unfp_pkg::*;
#(
   parameter int unsigned MaxPayload = MAX_PAYLOAD_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  filter_type filter,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] rx_byte,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   localparam logic [8:0] MAX_LEN = 9'(MaxPayload);

   typedef enum logic [3:0] {
      PH_SYNC1   = 4'd0,
      PH_SYNC2   = 4'd1,
      PH_CLASS   = 4'd2,
      PH_ID      = 4'd3,
      PH_LEN_LO  = 4'd4,
      PH_LEN_HI  = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_CK_A    = 4'd7,
      PH_CK_B    = 4'd8
   } phase_type;

   phase_type  phase_ff,  phase_in;
   logic [7:0] sum_a_ff,  sum_a_in;
   logic [7:0] sum_b_ff,  sum_b_in;
   logic [7:0] len_ff,    len_in;
   logic [7:0] count_ff,  count_in;
   logic       valid_ff;
   result_type result_ff, result_in;

   logic       accept;
   logic [7:0] acc_a;
   logic [7:0] acc_b;
   logic [7:0] count_next;
   logic       too_long;

   // output register frees up as the consumer takes it
   assign in_ready   = !valid_ff || out_ready;
   assign accept     = in_valid && in_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   assign acc_a      = sum_a_ff + rx_byte;
   assign acc_b      = sum_b_ff + acc_a;
   assign count_next = count_ff + 8'd1;
   assign too_long   = (rx_byte != 8'd0) || ({1'b0, len_ff} > MAX_LEN);

   always_comb begin
      phase_in  = phase_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      result_in = '0;
      unique case (phase_ff)
         PH_SYNC1: begin
            if (rx_byte == SYNC_FIRST) phase_in = PH_SYNC2;
         end
         PH_SYNC2: begin
            phase_in = (rx_byte == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
         end
         PH_CLASS: begin
            if (rx_byte != filter.class_filter) begin
               phase_in = PH_SYNC1;
            end else begin
               sum_a_in = rx_byte;
               sum_b_in = rx_byte;
               phase_in = PH_ID;
            end
         end
         PH_ID: begin
            if (rx_byte != filter.id_filter) begin
               phase_in = PH_SYNC1;
            end else begin
               sum_a_in = acc_a;
               sum_b_in = acc_b;
               phase_in = PH_LEN_LO;
            end
         end
         PH_LEN_LO: begin
            len_in   = rx_byte;
            sum_a_in = acc_a;
            sum_b_in = acc_b;
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            sum_a_in = acc_a;
            sum_b_in = acc_b;
            count_in = 8'd0;
            if (too_long) begin
               // length saturates to 255 when the high byte is set
               result_in.frame_status = STATUS_TOO_LONG;
               result_in.frame_length = (rx_byte != 8'd0) ? 8'hFF : len_ff;
               phase_in               = PH_SYNC1;
            end else if (len_ff != 8'd0) begin
               phase_in = PH_PAYLOAD;
            end else begin
               phase_in = PH_CK_A;
            end
         end
         PH_PAYLOAD: begin
            result_in.payload_byte  = rx_byte;
            result_in.payload_valid = 1'b1;
            result_in.payload_index = count_ff[6:0];
            sum_a_in = acc_a;
            sum_b_in = acc_b;
            count_in = count_next;
            if (count_next >= len_ff) phase_in = PH_CK_A;
         end
         PH_CK_A: begin
            if (rx_byte == sum_a_ff) begin
               phase_in = PH_CK_B;
            end else begin
               result_in.frame_status = STATUS_CK_FAIL;
               result_in.frame_length = len_ff;
               phase_in               = PH_SYNC1;
            end
         end
         PH_CK_B: begin
            result_in.frame_status = (rx_byte == sum_b_ff) ? STATUS_GOOD : STATUS_CK_FAIL;
            result_in.frame_length = len_ff;
            phase_in               = PH_SYNC1;
         end
         default: begin
            phase_in = PH_SYNC1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC1;
         sum_a_ff <= 8'd0;
         sum_b_ff <= 8'd0;
         len_ff   <= 8'd0;
         count_ff <= 8'd0;
         valid_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         sum_a_ff  <= sum_a_in;
         sum_b_ff  <= sum_b_in;
         len_ff    <= len_in;
         count_ff  <= count_in;
         result_ff <= result_in;
         valid_ff  <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // payload bytes never carry a frame status
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && result_ff.payload_valid |-> result_ff.frame_status == STATUS_NONE)
      else $error("payload byte reported with a frame status");

   // inside the payload the count stays below the declared length
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> count_ff < len_ff)
      else $error("payload count reached the frame length");

   // every accepted byte leaves a response in the register
   assert property (@(posedge clock) disable iff (reset)
      accept |=> valid_ff)
      else $error("accepted byte produced no response");

   // back pressure only while a response is held
   assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> valid_ff && !out_ready)
      else $error("request stalled with the response register free");

endmodule

// ===== design/ubx_nav_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// ubx_nav_frame_parser_core
// ubx frame parser with class/id filter and fletcher-8 check
// ----------------------------------------------------------------------------
//
//  channel  direction  item                       handshake
//  -------  ---------  -------------------------  ----------------------
//  req      in         one received byte          req_tvalid/req_tready
//  rsp      out        payload byte and status    rsp_tvalid/rsp_tready
//  csr      in         filter register write      csr_valid/csr_ready
//
//  one request per cycle while req_tready is high; its response sits in the
//  output register from the cycle after acceptance, set by the single parser state update
//  req_tready drops only while a response is held and rsp_tready is low
//  csr writes are always taken in the cycle they are offered
//  synchronous reset returns to the hunt for the first sync byte and
//  loads the nav/pvt filter defaults
//
module ubx_nav_frame_parser_core
   import unfp_pkg::*;
#(
   parameter int unsigned MaxPayload = MAX_PAYLOAD_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,

   // request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [7:0] rx_byte

   // response channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [31:0]                rsp_tdata,   // [7:0] payload_byte,
                                                   // [14:8] payload_index,
                                                   // [16:15] frame_status,
                                                   // [24:17] frame_length,
                                                   // [31:25] zero
   output logic                       rsp_tuser,   // [0] payload_valid

   // configuration channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                 csr_data
);

   filter_type filter;
   result_type result;

   // filter registers
   unfp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .filter    (filter)
   );

   // frame state machine and response register
   unfp_parser #(
      .MaxPayload (MaxPayload)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .filter     (filter),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .rx_byte    (req_tdata),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   // pack the response fields, lowest field first
   assign rsp_tdata = {7'd0,
                       result.frame_length,
                       result.frame_status,
                       result.payload_index,
                       result.payload_byte};
   assign rsp_tuser = result.payload_valid;

endmodule
